[sv/wlh_pkg.sv]
package wlh_pkg;

	// Histogram shape
	localparam int MAX_LEN     = 10;
	localparam int COUNT_WIDTH = 16;
	localparam int NUM_BINS    = MAX_LEN + 1;
	localparam int BIN_W       = $clog2(NUM_BINS);
	// Word length saturates at MAX_LEN+1
	localparam int LEN_W       = $clog2(MAX_LEN + 2);

	// Stream payload layout
	localparam int BYTE_W  = 8;
	localparam int IDX_W   = 4;
	localparam int FIELD_W = IDX_W + 2 * COUNT_WIDTH;
	localparam int DATA_W  = ((FIELD_W + 7) / 8) * 8;
	localparam int PAD_W   = DATA_W - FIELD_W;

	localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = '1;

	// Word separators
	localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
	localparam logic [BYTE_W-1:0] CH_NEWLINE = 8'h0A;
	localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;

	// Input kind carried in tuser
	localparam logic MODE_TEXT = 1'b0;
	localparam logic MODE_EOT  = 1'b1;

	// Controller to datapath
	typedef struct packed {
		logic accept_text;
		logic accept_eot;
		logic load_out;
		logic clear;
	} wlh_cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic rd_last;
	} wlh_sts_t;

endpackage

[sv/wlh_ctrl.sv]
module wlh_ctrl
	import wlh_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     s_tvalid,
	input  logic     s_tuser,
	output logic     s_tready,
	input  logic     m_tready,
	output logic     m_tvalid,
	input  wlh_sts_t sts,
	output wlh_cmd_t cmd
);

	typedef enum logic [1:0] {
		ST_IDLE = 2'b01,
		ST_READ = 2'b10
	} wlh_state_t;

	wlh_state_t state_q;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;

	// Command decode
	always_comb begin
		s_tready        = 1'b0;
		cmd.accept_text = 1'b0;
		cmd.accept_eot  = 1'b0;
		cmd.load_out    = 1'b0;
		cmd.clear       = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready        = 1'b1;
				cmd.accept_text = s_tvalid && (s_tuser == MODE_TEXT);
				cmd.accept_eot  = s_tvalid && (s_tuser == MODE_EOT);
			end
			ST_READ: begin
				cmd.load_out = out_free;
				cmd.clear    = out_free && sts.rd_last;
			end
			default: begin
				s_tready = 1'b0;
			end
		endcase
	end

	// State register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (cmd.accept_eot) state_q <= ST_READ;
				end
				ST_READ: begin
					if (cmd.clear) state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Output beat valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.load_out) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

endmodule

[sv/wlh_datapath.sv]
module wlh_datapath
	import wlh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic [BYTE_W-1:0] s_tdata,
	input  wlh_cmd_t          cmd,
	output wlh_sts_t          sts,
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast
);

	logic                   inside_q;
	logic [LEN_W-1:0]       len_q;
	logic [COUNT_WIDTH-1:0] cnt_q [NUM_BINS];
	logic [COUNT_WIDTH-1:0] peak_q;
	logic [BIN_W-1:0]       rd_idx_q;

	logic [IDX_W-1:0]       out_idx_q;
	logic [COUNT_WIDTH-1:0] out_cnt_q;
	logic [COUNT_WIDTH-1:0] out_peak_q;
	logic                   out_last_q;

	logic                   is_sep;
	logic                   close_word;
	logic                   do_count;
	logic [BIN_W-1:0]       bin_sel;
	logic [NUM_BINS-1:0]    bin_hit;
	logic [NUM_BINS-1:0]    peak_hit;

	assign is_sep = (s_tdata == CH_SPACE) || (s_tdata == CH_NEWLINE) || (s_tdata == CH_TAB);
	assign close_word = cmd.accept_eot || (cmd.accept_text && is_sep);
	assign do_count = close_word && inside_q;

	// Bin for the finished word; long words go to overflow
	assign bin_sel = (len_q <= LEN_W'(MAX_LEN)) ? BIN_W'(len_q - LEN_W'(1)) : BIN_W'(MAX_LEN);

	// Counts only step by one and never exceed the peak, so the peak
	// moves exactly when the bumped bin sat at the peak below saturation.
	always_comb begin
		for (int i = 0; i < NUM_BINS; i++) begin
			bin_hit[i]  = do_count && (bin_sel == BIN_W'(i)) && (cnt_q[i] != COUNT_MAX);
			peak_hit[i] = bin_hit[i] && (cnt_q[i] == peak_q);
		end
	end

	// Word tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			inside_q <= 1'b0;
			len_q    <= '0;
		end else if (close_word || cmd.clear) begin
			inside_q <= 1'b0;
			len_q    <= '0;
		end else if (cmd.accept_text) begin
			inside_q <= 1'b1;
			if (len_q < LEN_W'(MAX_LEN + 1)) len_q <= len_q + LEN_W'(1);
		end
	end

	// Bin counters and running peak
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_BINS; i++) cnt_q[i] <= '0;
			peak_q <= '0;
		end else if (cmd.clear) begin
			for (int i = 0; i < NUM_BINS; i++) cnt_q[i] <= '0;
			peak_q <= '0;
		end else begin
			for (int i = 0; i < NUM_BINS; i++) begin
				if (bin_hit[i]) cnt_q[i] <= cnt_q[i] + COUNT_WIDTH'(1);
			end
			if (|peak_hit) peak_q <= peak_q + COUNT_WIDTH'(1);
		end
	end

	// Readout pointer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rd_idx_q <= '0;
		end else if (cmd.clear) begin
			rd_idx_q <= '0;
		end else if (cmd.load_out) begin
			rd_idx_q <= rd_idx_q + BIN_W'(1);
		end
	end

	assign sts.rd_last = (rd_idx_q == BIN_W'(MAX_LEN));

	// Output beat register
	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			out_idx_q  <= IDX_W'(rd_idx_q);
			out_cnt_q  <= cnt_q[rd_idx_q];
			out_peak_q <= peak_q;
			out_last_q <= sts.rd_last;
		end
	end

	assign m_tdata = {{PAD_W{1'b0}}, out_peak_q, out_cnt_q, out_idx_q};
	assign m_tlast = out_last_q;

endmodule

[sv/word_length_histogram_core.sv]
// Word length histogram core.
// Slave stream: one beat per text byte, tdata = text byte, tuser = mode
// (0 text byte, 1 end of text). Text bytes are taken one per cycle while
// no readout runs and produce no output. Space, newline and tab end a word.
// End of text closes any pending word and starts a readout of all bins on
// the master stream: one beat per bin, bins 0 up to the overflow bin, with
// tlast on the overflow bin. Each beat carries the bin count and the peak.
// After the end-of-text beat is accepted the controller enters its read
// state, and each bin beat is registered from there once the output is
// free; the readout then moves one bin per cycle while the receiver
// takes beats. s_tready is low while the readout pointer steps through
// the bins, and input is taken again once the last bin has been loaded.
// A stalled master beat holds; readout resumes when m_tready returns.
// The histogram and word state are cleared as the last bin is loaded, so
// new text is taken while that last beat still waits at the output.
// Reset (arst_n low) clears all counts, the peak and the word state.
module word_length_histogram_core
	import wlh_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [BYTE_W-1:0] s_tdata,   // [7:0] text_byte
	input  logic              s_tuser,   // [0] mode
	output logic              m_tvalid,
	input  logic              m_tready,
	// [3:0] bin_index, [19:4] bin_count, [35:20] peak_count, rest zero
	output logic [DATA_W-1:0] m_tdata,
	output logic              m_tlast
);

	wlh_cmd_t cmd;
	wlh_sts_t sts;

	wlh_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tuser  (s_tuser),
		.s_tready (s_tready),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.sts      (sts),
		.cmd      (cmd)
	);

	wlh_datapath u_datapath (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tdata (s_tdata),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata),
		.m_tlast (m_tlast)
	);

endmodule

[sv/wlh_checker.sv]
module wlh_checker
	import wlh_pkg::*;
(
	input logic              clk,
	input logic              arst_n,
	input logic              s_tvalid,
	input logic              s_tready,
	input logic              s_tuser,
	input logic              m_tvalid,
	input logic              m_tready,
	input logic [DATA_W-1:0] m_tdata,
	input logic              m_tlast
);

	// Stalled output beat holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
		else $error("output beat changed while stalled");

	// Last beat is the overflow bin
	a_last_bin: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tlast |-> m_tdata[IDX_W-1:0] == IDX_W'(MAX_LEN))
		else $error("tlast on a bin other than overflow");

	// No bin count above the peak
	a_peak: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> m_tdata[IDX_W +: COUNT_WIDTH] <= m_tdata[IDX_W + COUNT_WIDTH +: COUNT_WIDTH])
		else $error("bin count above peak");

	// Text bytes never stall the input
	a_text_ready: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_TEXT) |=> s_tready)
		else $error("input stalled after a text byte");

	// End of text starts a readout that blocks input
	a_eot_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && (s_tuser == MODE_EOT) |=> !s_tready)
		else $error("input ready during readout");

endmodule

bind word_length_histogram_core wlh_checker u_wlh_checker (.*);

[verif/word_length_histogram_core_tb.sv]
`timescale 1ns / 100ps

module word_length_histogram_core_tb;
	import wlh_pkg::*;

	localparam int CLK_HALF       = 4;
	localparam int RESET_CYCLES   = 10;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int HOLD_CYCLES    = 300;
	localparam int MAX_REPORTS    = 10;
	localparam int DIR_ROWS       = 25;
	localparam logic [4:0] NO_BIN = 5'h1F;

	// One readout beat as the block should send it
	typedef struct packed {
		logic [IDX_W-1:0]       idx;
		logic [COUNT_WIDTH-1:0] count;
		logic [COUNT_WIDTH-1:0] peak;
		logic                   last;
	} bin_beat_t;

	// Directed row: typed rows carry a histogram with at most one nonzero bin
	typedef struct packed {
		logic                   mode;
		logic [BYTE_W-1:0]      ch;
		logic                   typed;
		logic [4:0]             hot_bin;
		logic [COUNT_WIDTH-1:0] hot_count;
	} dir_row_t;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [BYTE_W-1:0] s_tdata;
	logic              s_tuser;
	logic              m_tvalid;
	logic              m_tready;
	logic [DATA_W-1:0] m_tdata;
	logic              m_tlast;

	// Histogram predictor state
	logic                   in_word;
	logic [LEN_W-1:0]       pend_len;
	logic [COUNT_WIDTH-1:0] bin_tally [NUM_BINS];
	logic [COUNT_WIDTH-1:0] tally_peak;
	bin_beat_t              bin_readout_q [$];

	int  tx_idle_pct  = 0;
	int  rx_stall_pct = 0;
	bit  hold_req     = 1'b0;
	int  n_items      = 0;
	int  n_readouts   = 0;
	int  n_results    = 0;
	int  n_errors     = 0;
	int  idle_run     = 0;

	dir_row_t dir_tab [0:DIR_ROWS-1] = '{
		// end of text straight after reset: empty histogram
		'{MODE_EOT,  8'h00, 1'b1, NO_BIN, 16'd0},
		// one-letter word left open, closed by end of text
		'{MODE_TEXT, 8'h61, 1'b0, NO_BIN, 16'd0},
		'{MODE_EOT,  8'hFF, 1'b1, 5'd0,   16'd1},
		// twelve-byte word of odd bytes (NUL, CR, DEL, 0xFF) lands in overflow
		'{MODE_TEXT, 8'h00, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'hFF, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h0D, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h80, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h7F, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h01, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h08, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h0B, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h1F, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h21, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h41, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h7A, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, CH_TAB, 1'b0, NO_BIN, 16'd0},
		'{MODE_EOT,  8'h55, 1'b1, MAX_LEN[4:0], 16'd1},
		// separators outside a word and back to back
		'{MODE_TEXT, CH_NEWLINE, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h62, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h63, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, CH_SPACE, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, CH_SPACE, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, 8'h64, 1'b0, NO_BIN, 16'd0},
		'{MODE_TEXT, CH_NEWLINE, 1'b0, NO_BIN, 16'd0},
		'{MODE_EOT,  8'hAA, 1'b0, NO_BIN, 16'd0}
	};

	word_length_histogram_core u_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	// Clock
	always begin
		#CLK_HALF clk = 1'b1;
		#CLK_HALF clk = 1'b0;
	end

	function automatic bit is_separator(logic [BYTE_W-1:0] c);
		return c == CH_SPACE || c == CH_NEWLINE || c == CH_TAB;
	endfunction

	function automatic logic [BYTE_W-1:0] word_char();
		logic [BYTE_W-1:0] c;
		c = BYTE_W'($urandom_range(255));
		while (is_separator(c))
			c = BYTE_W'($urandom_range(255));
		return c;
	endfunction

	function automatic logic [BYTE_W-1:0] sep_char();
		case ($urandom_range(2))
			0: return CH_SPACE;
			1: return CH_NEWLINE;
			default: return CH_TAB;
		endcase
	endfunction

	function automatic void clear_histogram();
		in_word    = 1'b0;
		pend_len   = '0;
		tally_peak = '0;
		foreach (bin_tally[i])
			bin_tally[i] = '0;
	endfunction

	// Count the pending word in its bin, saturating, and track the peak
	function automatic void close_pending_word();
		int bin;
		if (in_word && pend_len != 0) begin
			bin = (pend_len <= MAX_LEN) ? int'(pend_len) - 1 : MAX_LEN;
			if (bin_tally[bin] != COUNT_MAX)
				bin_tally[bin] = bin_tally[bin] + 1'b1;
			if (bin_tally[bin] > tally_peak)
				tally_peak = bin_tally[bin];
		end
		in_word  = 1'b0;
		pend_len = '0;
	endfunction

	// Advance the histogram by one accepted beat; queue the readout on end of text
	function automatic void step_histogram(logic mode, logic [BYTE_W-1:0] ch, bit publish);
		bin_beat_t b;
		if (mode == MODE_TEXT) begin
			if (is_separator(ch)) begin
				close_pending_word();
			end else begin
				in_word = 1'b1;
				if (pend_len < MAX_LEN + 1)
					pend_len = pend_len + 1'b1;
			end
		end else begin
			close_pending_word();
			n_readouts++;
			if (publish) begin
				for (int i = 0; i < NUM_BINS; i++) begin
					b.idx   = IDX_W'(i);
					b.count = bin_tally[i];
					b.peak  = tally_peak;
					b.last  = (i == NUM_BINS - 1);
					bin_readout_q.push_back(b);
				end
			end
			clear_histogram();
		end
	endfunction

	// Offer one beat from a falling edge; returns at the falling edge after acceptance
	task automatic send_beat(input logic mode, input logic [BYTE_W-1:0] ch, input bit publish);
		while ($urandom_range(99) < tx_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= mode;
		s_tdata  <= ch;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		n_items++;
		step_histogram(mode, ch, publish);
		@(negedge clk);
	endtask

	// Mostly well-formed words with random bytes, some noise, ends with end of text
	task automatic send_random_text(input int tx_pct, input int rx_pct, input int n_target);
		int start;
		int len;
		int r;
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		start = n_items;
		while (n_items - start < n_target) begin
			if ($urandom_range(99) < 85) begin
				r = $urandom_range(9);
				if (r < 7)
					len = $urandom_range(1, MAX_LEN);
				else if (r < 9)
					len = $urandom_range(MAX_LEN + 1, MAX_LEN + 3);
				else
					len = $urandom_range(MAX_LEN + 4, 2 * MAX_LEN);
				repeat (len)
					send_beat(MODE_TEXT, word_char(), 1'b1);
				if ($urandom_range(5) == 0) begin
					send_beat(MODE_EOT, BYTE_W'($urandom_range(255)), 1'b1);
				end else begin
					repeat ($urandom_range(1, 3))
						send_beat(MODE_TEXT, sep_char(), 1'b1);
					if ($urandom_range(9) == 0)
						send_beat(MODE_EOT, BYTE_W'($urandom_range(255)), 1'b1);
				end
			end else begin
				repeat ($urandom_range(1, 4))
					send_beat(($urandom_range(9) == 0) ? MODE_EOT : MODE_TEXT,
						BYTE_W'($urandom_range(255)), 1'b1);
			end
		end
		send_beat(MODE_EOT, BYTE_W'($urandom_range(255)), 1'b1);
	endtask

	// Receiver: random stalls, plus a long hold-off whenever hold_req toggles
	initial begin : sink
		bit hold_ack;
		int hold_left;
		hold_ack  = 1'b0;
		hold_left = 0;
		m_tready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_ack) begin
				hold_ack  = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= rx_stall_pct);
			end
		end
	end

	task automatic note_mismatch(input string what, input int unsigned want,
		input int unsigned got);
		n_errors++;
		if (n_errors <= MAX_REPORTS)
			$display("mismatch @%0t: %s expected %0d got %0d", $realtime, what, want, got);
	endtask

	// Readout checker
	always @(posedge clk) begin
		bin_beat_t want;
		if (arst_n && m_tvalid && m_tready) begin
			n_results++;
			if (bin_readout_q.size() == 0) begin
				note_mismatch("unexpected beat, bin_index", 0, m_tdata[IDX_W-1:0]);
			end else begin
				want = bin_readout_q.pop_front();
				if (m_tdata[IDX_W-1:0] !== want.idx)
					note_mismatch("bin_index", want.idx, m_tdata[IDX_W-1:0]);
				if (m_tdata[IDX_W +: COUNT_WIDTH] !== want.count)
					note_mismatch("bin_count", want.count, m_tdata[IDX_W +: COUNT_WIDTH]);
				if (m_tdata[IDX_W + COUNT_WIDTH +: COUNT_WIDTH] !== want.peak)
					note_mismatch("peak_count", want.peak,
						m_tdata[IDX_W + COUNT_WIDTH +: COUNT_WIDTH]);
				if (m_tlast !== want.last)
					note_mismatch("last", want.last, m_tlast);
			end
		end
	end

	// Watchdog on cycles with no beat moving on either side
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				idle_run <= 0;
			else
				idle_run <= idle_run + 1;
			if (idle_run >= WATCHDOG_LIMIT) begin
				$display("watchdog: no beat for %0d cycles, %0d readout beats pending",
					idle_run, bin_readout_q.size());
				$display("TB_ERROR");
				$finish;
			end
		end
	end

	// Stimulus
	initial begin : stim
		bin_beat_t b;
		arst_n   = 1'b0;
		s_tvalid = 1'b0;
		s_tdata  = '0;
		s_tuser  = MODE_TEXT;
		clear_histogram();
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// Directed table, no idling
		foreach (dir_tab[i]) begin
			send_beat(dir_tab[i].mode, dir_tab[i].ch, !dir_tab[i].typed);
			if (dir_tab[i].typed) begin
				for (int k = 0; k < NUM_BINS; k++) begin
					b.idx   = IDX_W'(k);
					b.count = (k == dir_tab[i].hot_bin) ? dir_tab[i].hot_count : '0;
					b.peak  = dir_tab[i].hot_count;
					b.last  = (k == NUM_BINS - 1);
					bin_readout_q.push_back(b);
				end
			end
		end

		// Random text under each idling mix
		send_random_text(0, 0, 55);
		send_random_text(58, 0, 55);
		send_random_text(0, 58, 55);
		send_random_text(9, 9, 55);

		// Receiver holds off while text keeps coming, so the input backs up
		hold_req = !hold_req;
		send_random_text(0, 0, 35);
		s_tvalid <= 1'b0;

		while (bin_readout_q.size() != 0)
			@(posedge clk);
		repeat (2 * NUM_BINS) @(posedge clk);

		$display("Ran %0d text and end-of-text beats, %0d readouts, %0d bin beats checked.",
			n_items, n_readouts, n_results);
		$display("Covered separators, overlong words, empty text and a long receiver hold-off.");
		if (n_errors == 0) begin
			$display("TB_OK");
		end else begin
			$display("%0d mismatches", n_errors);
			$display("TB_ERROR");
		end
		$finish;
	end

endmodule
